/* hdl/ola_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the overlap-add frame buffer.
// No dependencies; imported by ola_out_fifo, overlap_add_frame_buffer and the test bench.
package ola_pkg;

    // Configuration register widths and reset values
    localparam int HOP_W = 8;
    localparam int OVL_W = 4;
    localparam logic [HOP_W-1:0] HOP_RESET = 8'd64;
    localparam logic [OVL_W-1:0] OVL_RESET = 4'd4;

    // Register index, taken from the word address bit of paddr
    typedef enum logic {
        REG_HOP_LENGTH    = 1'b0,
        REG_OVERLAP_COUNT = 1'b1
    } t_reg_idx;

    // Result queue geometry
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W     = 2;
    localparam int FIFO_CNT_W     = 3;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_stat;

endpackage

/* hdl/ola_out_fifo.sv */
`timescale 1ns / 1ps
// Small result queue that parts the accumulator pipeline from the output channel.
// Depends on ola_pkg for depth, pointer widths and the status struct.
module ola_out_fifo import ola_pkg::*; #(
    parameter int DW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_push_data,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop_ready,
    output t_fifo_stat    o_stat
);

    logic [DW-1:0]         r_mem [OUT_FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;

    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign pop          = o_valid && i_pop_ready;
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/overlap_add_frame_buffer.sv */
`timescale 1ns / 1ps
// Overlap-add frame buffer: sums overlapping frames into a circular accumulator.
// Accepted words pass a stage 1 register; finished ones queue for o_out_valid.
// Throughput: one word per cycle while o_in_ready is high, set by the single
// accumulator memory doing one read-modify-write per word (registered read,
// write-back in the next, forwarded). Reset: synchronous, active low; then a
// clearing pass zeroes all MAX_FRAME slots, o_in_ready held low (register writes taken).
module overlap_add_frame_buffer import ola_pkg::*; #(
    parameter int MAX_FRAME   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB-style register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_hop_end
);

    // Accumulator carries three guard bits over the sample
    localparam int ACC_BITS = SAMPLE_BITS + 3;
    localparam int SUM_BITS = ACC_BITS + 1;
    // Ring address width, and a count width that holds frame lengths and pointer sums
    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = (12 > AW + 1) ? 12 : AW + 1;
    localparam int QW = SAMPLE_BITS + 1;

    localparam logic signed [SUM_BITS-1:0] S_HI = {5'b00000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] S_LO = {5'b11111, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0] A_HI = {2'b00, {(SAMPLE_BITS+2){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] A_LO = {2'b11, {(SAMPLE_BITS+2){1'b0}}};
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_FRAME - 1);
    localparam logic [CW-1:0] FRAME_CAP = CW'(MAX_FRAME);

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    logic [HOP_W-1:0] r_hop_length;
    logic [OVL_W-1:0] r_overlap_count;
    logic             cfg_write;
    t_reg_idx         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop_length    <= HOP_RESET;
            r_overlap_count <= OVL_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_HOP_LENGTH:    r_hop_length    <= pwdata[HOP_W-1:0];
                REG_OVERLAP_COUNT: r_overlap_count <= pwdata[OVL_W-1:0];
                default:           r_hop_length    <= r_hop_length;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_HOP_LENGTH:    prdata = {{(32-HOP_W){1'b0}}, r_hop_length};
            REG_OVERLAP_COUNT: prdata = {{(32-OVL_W){1'b0}}, r_overlap_count};
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Frame geometry: zero counts act as one, frame capped at MAX_FRAME,
    // hop capped at the frame length.
    // ---------------------------------------------------------------
    logic [CW-1:0] hop_one;
    logic [CW-1:0] ovl_one;
    logic [CW-1:0] frame_prod;
    logic [CW-1:0] frame_len;
    logic [CW-1:0] hop_len;

    assign hop_one    = (r_hop_length == '0) ? CW'(1) : CW'(r_hop_length);
    assign ovl_one    = (r_overlap_count == '0) ? CW'(1) : CW'(r_overlap_count);
    assign frame_prod = hop_one * ovl_one;
    assign frame_len  = (frame_prod > FRAME_CAP) ? FRAME_CAP : frame_prod;
    assign hop_len    = (hop_one > frame_len) ? frame_len : hop_one;

    // ---------------------------------------------------------------
    // Pointers and slot address for the word on offer
    // ---------------------------------------------------------------
    logic [AW-1:0] r_ring_base;
    logic [AW-1:0] r_frame_pos;
    logic [CW-1:0] base_eff;
    logic [CW-1:0] pos_eff;
    logic [CW-1:0] slot_sum;
    logic [CW-1:0] slot_wrap;
    logic [AW-1:0] slot;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] base_inc;
    logic [CW-1:0] base_wrap;
    logic [AW-1:0] n_frame_pos;
    logic [AW-1:0] n_ring_base;
    logic          emit;
    logic          hop_last;

    // Stale pointers after a register change fall back to the frame start
    assign base_eff  = (CW'(r_ring_base) >= frame_len) ? '0 : CW'(r_ring_base);
    assign pos_eff   = (CW'(r_frame_pos) >= frame_len) ? '0 : CW'(r_frame_pos);
    assign slot_sum  = base_eff + pos_eff;
    assign slot_wrap = (slot_sum >= frame_len) ? (slot_sum - frame_len) : slot_sum;
    assign slot      = slot_wrap[AW-1:0];

    assign emit     = (pos_eff < hop_len);
    assign hop_last = (pos_eff == (hop_len - CW'(1)));

    // Advance the frame position; at frame end move the base on by one hop
    assign pos_inc   = pos_eff + CW'(1);
    assign base_inc  = base_eff + hop_len;
    assign base_wrap = (base_inc >= frame_len) ? (base_inc - frame_len) : base_inc;

    always_comb begin
        if (pos_inc >= frame_len) begin
            n_frame_pos = '0;
            n_ring_base = base_wrap[AW-1:0];
        end else begin
            n_frame_pos = pos_inc[AW-1:0];
            n_ring_base = base_eff[AW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Input handshake: hold off while clearing or when the result queue
    // could not take the word already in flight plus this one.
    // ---------------------------------------------------------------
    t_fifo_stat              fifo_stat;
    logic                    r_clearing;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_p1_valid;
    logic [FIFO_CNT_W:0]     occupancy;
    logic                    accept;

    assign occupancy  = (FIFO_CNT_W+1)'(fifo_stat.count) + (FIFO_CNT_W+1)'(r_p1_valid);
    assign o_in_ready = !r_clearing && (occupancy < (FIFO_CNT_W+1)'(OUT_FIFO_DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_base <= '0;
            r_frame_pos <= '0;
        end else if (accept) begin
            r_ring_base <= n_ring_base;
            r_frame_pos <= n_frame_pos;
        end
    end

    // Clearing pass after reset, one slot per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: read data back; add, saturate, write back, queue result.
    // ---------------------------------------------------------------
    logic [AW-1:0]                 r_p1_addr;
    logic signed [SAMPLE_BITS-1:0] r_p1_sample;
    logic                          r_p1_emit;
    logic                          r_p1_hop_end;
    logic                          r_p1_fwd;
    logic signed [ACC_BITS-1:0]    r_fwd_data;
    logic signed [ACC_BITS-1:0]    r_rd_data;
    logic signed [ACC_BITS-1:0]    r_acc_mem [MAX_FRAME];

    logic signed [ACC_BITS-1:0]    acc_cur;
    logic signed [SUM_BITS-1:0]    acc_sum;
    logic signed [SUM_BITS-1:0]    out_sat;
    logic signed [SUM_BITS-1:0]    acc_sat;
    logic signed [ACC_BITS-1:0]    wb_data;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic signed [ACC_BITS-1:0]    mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p1_fwd   <= 1'b0;
        end else begin
            r_p1_valid <= accept;
            // Same slot written back at this edge: the memory read returns stale data
            r_p1_fwd   <= accept && r_p1_valid && (slot == r_p1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_addr    <= slot;
            r_p1_sample  <= i_in_sample;
            r_p1_emit    <= emit;
            r_p1_hop_end <= hop_last;
        end
        if (r_p1_valid) begin
            r_fwd_data <= wb_data;
        end
    end

    assign acc_cur = r_p1_fwd ? r_fwd_data : r_rd_data;
    assign acc_sum = {acc_cur[ACC_BITS-1], acc_cur}
                   + {{4{r_p1_sample[SAMPLE_BITS-1]}}, r_p1_sample};

    always_comb begin
        if (acc_sum > S_HI) begin
            out_sat = S_HI;
        end else if (acc_sum < S_LO) begin
            out_sat = S_LO;
        end else begin
            out_sat = acc_sum;
        end
        if (acc_sum > A_HI) begin
            acc_sat = A_HI;
        end else if (acc_sum < A_LO) begin
            acc_sat = A_LO;
        end else begin
            acc_sat = acc_sum;
        end
    end

    // Finished slots are emptied for the frame that lands there next
    assign wb_data   = r_p1_emit ? '0 : acc_sat[ACC_BITS-1:0];
    assign mem_we    = r_clearing || r_p1_valid;
    assign mem_waddr = r_clearing ? r_clr_addr : r_p1_addr;
    assign mem_wdata = r_clearing ? '0 : wb_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_acc_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= r_acc_mem[slot];
        end
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic [QW-1:0] q_data;

    assign q_push      = r_p1_valid && r_p1_emit;
    assign q_push_data = {r_p1_hop_end, out_sat[SAMPLE_BITS-1:0]};

    ola_out_fifo #(
        .DW (QW)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_valid     (o_out_valid),
        .o_data      (q_data),
        .i_pop_ready (i_out_ready),
        .o_stat      (fifo_stat)
    );

    assign o_out_sample = q_data[SAMPLE_BITS-1:0];
    assign o_hop_end    = q_data[QW-1];

endmodule

/* hdl/ola_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the overlap-add frame buffer, bound to the top level.
// Depends only on the ports of overlap_add_frame_buffer.
module ola_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_out_sample,
    input logic                   o_hop_end
);

    // Reset drops all queued results
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Clearing pass holds the input off straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input taken during accumulator clear");

    // A result appears on an empty output only after a word was taken and passed stage 1
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without matching input word");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_sample) && $stable(o_hop_end))
        else $error("stalled result changed");

endmodule

bind overlap_add_frame_buffer ola_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ola_checker (.*);

/* verif/overlap_add_frame_buffer_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for overlap_add_frame_buffer: random words through both handshakes,
// register changes between phases, a scoreboard class that mirrors the overlap-add sums.
// Depends on ola_pkg and the overlap_add_frame_buffer RTL only.

typedef struct {
    logic signed [23:0] sample;
    logic               hop_end;
} ola_expected_t;

// Mirrors the accumulator ring and pointers; predicts finished samples per accepted word.
class ola_scoreboard;
    logic signed [26:0] acc_ring [1024];
    int unsigned        ring_base;
    int unsigned        frame_pos;
    int unsigned        hop_reg;
    int unsigned        ovl_reg;
    ola_expected_t      finished_q [$];
    int                 errors;

    function new();
        for (int i = 0; i < 1024; i++) acc_ring[i] = '0;
        ring_base = 0;
        frame_pos = 0;
        hop_reg   = ola_pkg::HOP_RESET;
        ovl_reg   = ola_pkg::OVL_RESET;
        errors    = 0;
    endfunction

    function void set_reg(ola_pkg::t_reg_idx idx, logic [31:0] value);
        if (idx == ola_pkg::REG_HOP_LENGTH) hop_reg = value[7:0];
        else ovl_reg = value[3:0];
    endfunction

    function longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the mirror by one accepted input word.
    function void note_sample(logic signed [23:0] x);
        int unsigned   h;
        int unsigned   ov;
        int unsigned   f;
        int unsigned   slot;
        longint        sum;
        ola_expected_t e;
        h  = (hop_reg != 0) ? hop_reg : 1;
        ov = (ovl_reg != 0) ? ovl_reg : 1;
        f  = h * ov;
        if (f > 1024) f = 1024;
        if (h > f) h = f;
        // pointers left over from a larger frame fall back to the start
        if (ring_base >= f) ring_base = 0;
        if (frame_pos >= f) frame_pos = 0;
        slot = ring_base + frame_pos;
        if (slot >= f) slot -= f;
        sum = longint'(acc_ring[slot]) + longint'(x);
        if (frame_pos < h) begin
            e.sample  = 24'(clamp(sum, 24));
            e.hop_end = (frame_pos == h - 1);
            finished_q.push_back(e);
            acc_ring[slot] = '0;
        end else begin
            acc_ring[slot] = 27'(clamp(sum, 27));
        end
        frame_pos++;
        if (frame_pos >= f) begin
            frame_pos = 0;
            ring_base += h;
            if (ring_base >= f) ring_base -= f;
        end
    endfunction

    function void check_result(logic signed [23:0] sample, logic hop_end);
        ola_expected_t e;
        if (finished_q.size() == 0) begin
            $display("%0t: unexpected word: expected none, got sample %0d hop_end %0b",
                     $time, sample, hop_end);
            errors++;
            return;
        end
        e = finished_q.pop_front();
        if (sample !== e.sample) begin
            $display("%0t: out_sample mismatch: expected %0d, got %0d", $time, e.sample, sample);
            errors++;
        end
        if (hop_end !== e.hop_end) begin
            $display("%0t: hop_end mismatch: expected %0b, got %0b", $time, e.hop_end, hop_end);
            errors++;
        end
    endfunction

    function int pending();
        return finished_q.size();
    endfunction

    function void flag_leftovers();
        if (finished_q.size() != 0) begin
            $display("%0t: %0d finished samples never arrived, expected next %0d",
                     $time, finished_q.size(), finished_q[0].sample);
            errors += finished_q.size();
        end
    endfunction
endclass

module overlap_add_frame_buffer_test;
    import ola_pkg::*;

    // The clearing pass after reset takes no word; allow for it plus the longest
    // stall on either side, several times over.
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_WORDS   = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               o_in_ready;
    logic signed [23:0] in_sample;
    logic               o_out_valid;
    logic               out_ready;
    logic signed [23:0] o_out_sample;
    logic               o_hop_end;

    ola_scoreboard sb = new();

    // Phase controls: calm switches off idling on both sides, mix biases the samples.
    bit     calm;
    int     mix;
    int     out_stall;
    int     idle_cycles;
    int     words_sent;

    always #5 i_clk = ~i_clk;

    overlap_add_frame_buffer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_sample  (in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_sample (o_out_sample),
        .o_hop_end    (o_hop_end)
    );

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Sample content: full range, pinned near either rail to drive the sums
    // into saturation, or small values that keep them in range.
    function automatic logic signed [23:0] pick_sample();
        case (mix)
            1: begin
                if ($urandom_range(0, 9) < 8) return 24'sh7FFFFF;
                return 24'($urandom);
            end
            2: begin
                if ($urandom_range(0, 9) < 8) return -24'sh800000;
                return 24'($urandom);
            end
            3: return 24'($signed($urandom_range(0, 511)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    // Watch both channels: note accepted inputs, check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) sb.note_sample(in_sample);
            if (o_out_valid && out_ready) sb.check_result(o_out_sample, o_hop_end);
        end
    end

    // Result side back-pressure: hold ready low for random stalls.
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30) out_stall <= pick_gap();
        end
    end

    // Drop the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Write one register through a setup and an access cycle, then idle the bus.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Offer one word; keep valid high and the payload steady until it is taken.
    task automatic send_word(input logic signed [23:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_sample <= x;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // Stop offering words, let every finished sample out, then let the
    // pipeline settle since the last words may have caused no result.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [7:0] hop, input logic [3:0] ovl);
        reg_write(REG_HOP_LENGTH, {24'(0), hop});
        reg_write(REG_OVERLAP_COUNT, {28'(0), ovl});
    endtask

    initial begin
        logic [7:0] hop;
        logic [3:0] ovl;
        int         n;
        i_rst_n   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        in_sample <= '0;
        out_ready <= 1'b1;
        out_stall <= 0;
        idle_cycles <= 0;
        calm       = 1'b0;
        mix        = 0;
        words_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: rails and bit patterns at the reset frame (hop 64, overlap 4)
        send_word(24'sh7FFFFF);
        send_word(-24'sh800000);
        send_word(24'sh000000);
        send_word(-24'sh000001);
        send_word(24'sh000001);
        send_word(24'sh555555);
        send_word(24'shAAAAAA);
        send_word(24'sh7FFFFF);
        send_word(24'sh7FFFFF);
        send_word(-24'sh800000);
        send_word(-24'sh800000);
        send_word(24'sh123456);
        drain();

        // Zero hop and zero overlap act as one: every word comes straight back,
        // and the pointers left mid-frame must fall back to the start.
        set_frame(8'd0, 4'd0);
        send_word(24'sh7FFFFF);
        send_word(-24'sh800000);
        send_word(24'sh000000);
        send_word(-24'sh000001);
        send_word(24'shABCDEF);
        send_word(24'sh000001);
        drain();

        // Oversized frame: hop and overlap both at full width, frame pinned at maximum
        set_frame(8'hFF, 4'hF);
        send_word(24'sh7FFFFF);
        send_word(-24'sh800000);
        send_word(24'sh3C3C3C);
        send_word(-24'sh000001);
        send_word(24'sh000000);
        drain();

        // Random phases; the accumulator is never cleared between them.
        while (words_sent < RANDOM_WORDS + 23) begin
            case ($urandom_range(0, 5))
                0: hop = 8'd2;
                1: hop = 8'd128;
                2: hop = $urandom_range(0, 1) ? 8'hFF : 8'd0;
                3: hop = 8'($urandom_range(1, 8));
                default: hop = 8'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: ovl = 4'd1;
                1: ovl = 4'd8;
                2: ovl = $urandom_range(0, 1) ? 4'hF : 4'd0;
                default: ovl = 4'($urandom);
            endcase
            calm = ($urandom_range(0, 4) == 0);
            mix  = $urandom_range(0, 3);
            set_frame(hop, ovl);
            // keep phases short so large frames do not swallow the run
            n = $urandom_range(20, 250);
            repeat (n) send_word(pick_sample());
            drain();
        end

        calm = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
